// ===== rtl/dhcp_pkg.sv =====
// Shared types, constants and a helper function of the DHCP request classifier.
`timescale 1ns / 1ps

package dhcp_pkg;

  // Message layout.
  localparam int OPTION_AREA_BYTES_DEFAULT = 312;
  localparam int HEADER_BYTES = 240;
  localparam int XID_FIRST = 4;
  localparam int XID_END = 8;
  localparam int CHADDR_HIGH_FIRST = 28;
  localparam int CHADDR_LOW_FIRST = 36;
  localparam int CHADDR_END = 44;
  localparam int COOKIE_FIRST = 236;

  // Field codes.
  localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_END = 8'hFF;
  localparam logic [7:0] OPT_PAD = 8'h00;
  localparam logic [7:0] OP_REQUEST = 8'd1;
  localparam logic [7:0] MSG_DISCOVER = 8'd1;
  localparam logic [7:0] MSG_REQUEST = 8'd3;
  localparam logic [7:0] TYPE_LEN = 8'd1;

  typedef enum logic [2:0] {
    STATUS_OFFER       = 3'd0,
    STATUS_ACK         = 3'd1,
    STATUS_TOO_SHORT   = 3'd2,
    STATUS_NOT_REQUEST = 3'd3,
    STATUS_BAD_COOKIE  = 3'd4,
    STATUS_UNSUPPORTED = 3'd5
  } dhcp_status_t;

  // Option walker phases, one-hot.
  typedef enum logic [3:0] {
    PH_CODE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_SKIP  = 4'b0100,
    PH_VALUE = 4'b1000
  } opt_phase_t;

  // One byte handed from the input register to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } dhcp_step_t;

  // One classification result.
  typedef struct packed {
    dhcp_status_t status;
    logic [31:0]  xid;
    logic [63:0]  chaddr_high;
    logic [63:0]  chaddr_low;
  } dhcp_result_t;

  // Expected cookie byte for a position within the four cookie bytes.
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = MAGIC_COOKIE[31:24];
      2'd1: b = MAGIC_COOKIE[23:16];
      2'd2: b = MAGIC_COOKIE[15:8];
      default: b = MAGIC_COOKIE[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/dhcp_in_if.sv =====
// Byte stream channel carrying the DHCP payload into the classifier.
`timescale 1ns / 1ps

interface dhcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/dhcp_out_if.sv =====
// Result channel carrying one classification status per message.
`timescale 1ns / 1ps

interface dhcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] transaction_id;
  logic [63:0] client_addr_high;
  logic [63:0] client_addr_low;

  modport source (
    output valid, output status, output transaction_id,
    output client_addr_high, output client_addr_low, input ready
  );
  modport sink (
    input valid, input status, input transaction_id,
    input client_addr_high, input client_addr_low, output ready
  );
endinterface

// ===== rtl/dhcp_parser.sv =====
// Header field capture, cookie check and option walk for one message.
`timescale 1ns / 1ps

module dhcp_parser #(
  parameter int OPTION_AREA_BYTES = dhcp_pkg::OPTION_AREA_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dhcp_pkg::dhcp_step_t  step,
  output dhcp_pkg::dhcp_result_t result
);

  localparam int MSG_LIMIT = dhcp_pkg::HEADER_BYTES + OPTION_AREA_BYTES;
  localparam int POS_W = $clog2(MSG_LIMIT + 1);

  localparam logic [POS_W-1:0] LIMIT_POS = POS_W'(MSG_LIMIT);
  localparam logic [POS_W-1:0] HEADER_POS = POS_W'(dhcp_pkg::HEADER_BYTES);
  localparam logic [POS_W-1:0] XID_FIRST_POS = POS_W'(dhcp_pkg::XID_FIRST);
  localparam logic [POS_W-1:0] XID_END_POS = POS_W'(dhcp_pkg::XID_END);
  localparam logic [POS_W-1:0] HI_FIRST_POS = POS_W'(dhcp_pkg::CHADDR_HIGH_FIRST);
  localparam logic [POS_W-1:0] LO_FIRST_POS = POS_W'(dhcp_pkg::CHADDR_LOW_FIRST);
  localparam logic [POS_W-1:0] HW_END_POS = POS_W'(dhcp_pkg::CHADDR_END);
  localparam logic [POS_W-1:0] COOKIE_POS = POS_W'(dhcp_pkg::COOKIE_FIRST);

  logic [POS_W-1:0]     byte_position, byte_position_next, pos_upd;
  logic                 op_is_request, op_is_request_next, op_upd;
  logic                 cookie_matches, cookie_matches_next, cookie_upd;
  logic [31:0]          xid_shift, xid_shift_next, xid_upd;
  logic [63:0]          hw_high, hw_high_next, hw_high_upd;
  logic [63:0]          hw_low, hw_low_next, hw_low_upd;
  dhcp_pkg::opt_phase_t option_phase, option_phase_next, phase_upd;
  logic [7:0]           option_code_seen, option_code_seen_next, code_upd;
  logic [8:0]           skip_remaining, skip_remaining_next, skip_upd;
  logic [7:0]           found_type, found_type_next, type_upd;
  logic                 walk_done, walk_done_next, done_upd;
  logic [8:0]           skip_dec;
  logic [7:0]           b;

  assign b = step.data;
  assign skip_dec = skip_remaining - 9'd1;

  // State update for the byte that is consumed this cycle.
  always_comb begin
    pos_upd     = byte_position;
    op_upd      = op_is_request;
    cookie_upd  = cookie_matches;
    xid_upd     = xid_shift;
    hw_high_upd = hw_high;
    hw_low_upd  = hw_low;
    phase_upd   = option_phase;
    code_upd    = option_code_seen;
    skip_upd    = skip_remaining;
    type_upd    = found_type;
    done_upd    = walk_done;
    if (step.valid && (byte_position < LIMIT_POS)) begin
      pos_upd = byte_position + POS_W'(1);
      if (byte_position == '0) begin
        op_upd = (b == dhcp_pkg::OP_REQUEST);
      end else if ((byte_position >= XID_FIRST_POS) && (byte_position < XID_END_POS)) begin
        xid_upd = {xid_shift[23:0], b};
      end else if ((byte_position >= HI_FIRST_POS) && (byte_position < LO_FIRST_POS)) begin
        hw_high_upd = {hw_high[55:0], b};
      end else if ((byte_position >= LO_FIRST_POS) && (byte_position < HW_END_POS)) begin
        hw_low_upd = {hw_low[55:0], b};
      end else if ((byte_position >= COOKIE_POS) && (byte_position < HEADER_POS)) begin
        if (b != dhcp_pkg::cookie_byte(byte_position[1:0])) begin
          cookie_upd = 1'b0;
        end
      end else if ((byte_position >= HEADER_POS) && !walk_done) begin
        // Option walk: pad is skipped, end stops, a message-type value is captured, others skip by length.
        unique case (option_phase)
          dhcp_pkg::PH_CODE: begin
            if (b == dhcp_pkg::OPT_END) begin
              done_upd = 1'b1;
            end else if (b != dhcp_pkg::OPT_PAD) begin
              code_upd  = b;
              phase_upd = dhcp_pkg::PH_LEN;
            end
          end
          dhcp_pkg::PH_LEN: begin
            if ((option_code_seen == dhcp_pkg::OPT_MSG_TYPE) && (b == dhcp_pkg::TYPE_LEN)) begin
              phase_upd = dhcp_pkg::PH_VALUE;
            end else if (b == 8'd0) begin
              phase_upd = dhcp_pkg::PH_CODE;
            end else begin
              skip_upd  = {1'b0, b};
              phase_upd = dhcp_pkg::PH_SKIP;
            end
          end
          dhcp_pkg::PH_SKIP: begin
            skip_upd = skip_dec;
            if (skip_dec == 9'd0) begin
              phase_upd = dhcp_pkg::PH_CODE;
            end
          end
          dhcp_pkg::PH_VALUE: begin
            type_upd = b;
            done_upd = 1'b1;
          end
          default: begin
            phase_upd = dhcp_pkg::PH_CODE;
          end
        endcase
      end
    end
  end

  // Classification of the message as it stands after this byte.
  always_comb begin
    if (pos_upd < HEADER_POS) begin
      result.status = dhcp_pkg::STATUS_TOO_SHORT;
    end else if (!op_upd) begin
      result.status = dhcp_pkg::STATUS_NOT_REQUEST;
    end else if (!cookie_upd) begin
      result.status = dhcp_pkg::STATUS_BAD_COOKIE;
    end else if (type_upd == dhcp_pkg::MSG_DISCOVER) begin
      result.status = dhcp_pkg::STATUS_OFFER;
    end else if (type_upd == dhcp_pkg::MSG_REQUEST) begin
      result.status = dhcp_pkg::STATUS_ACK;
    end else begin
      result.status = dhcp_pkg::STATUS_UNSUPPORTED;
    end
    result.xid         = xid_upd;
    result.chaddr_high = hw_high_upd;
    result.chaddr_low  = hw_low_upd;
  end

  // The last byte of a message returns every field to its reset value.
  always_comb begin
    if (step.valid && step.last) begin
      byte_position_next    = '0;
      op_is_request_next    = 1'b0;
      cookie_matches_next   = 1'b1;
      xid_shift_next        = '0;
      hw_high_next          = '0;
      hw_low_next           = '0;
      option_phase_next     = dhcp_pkg::PH_CODE;
      option_code_seen_next = '0;
      skip_remaining_next   = '0;
      found_type_next       = '0;
      walk_done_next        = 1'b0;
    end else begin
      byte_position_next    = pos_upd;
      op_is_request_next    = op_upd;
      cookie_matches_next   = cookie_upd;
      xid_shift_next        = xid_upd;
      hw_high_next          = hw_high_upd;
      hw_low_next           = hw_low_upd;
      option_phase_next     = phase_upd;
      option_code_seen_next = code_upd;
      skip_remaining_next   = skip_upd;
      found_type_next       = type_upd;
      walk_done_next        = done_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      op_is_request    <= 1'b0;
      cookie_matches   <= 1'b1;
      xid_shift        <= '0;
      hw_high          <= '0;
      hw_low           <= '0;
      option_phase     <= dhcp_pkg::PH_CODE;
      option_code_seen <= '0;
      skip_remaining   <= '0;
      found_type       <= '0;
      walk_done        <= 1'b0;
    end else begin
      byte_position    <= byte_position_next;
      op_is_request    <= op_is_request_next;
      cookie_matches   <= cookie_matches_next;
      xid_shift        <= xid_shift_next;
      hw_high          <= hw_high_next;
      hw_low           <= hw_low_next;
      option_phase     <= option_phase_next;
      option_code_seen <= option_code_seen_next;
      skip_remaining   <= skip_remaining_next;
      found_type       <= found_type_next;
      walk_done        <= walk_done_next;
    end
  end

  // The position never runs past the message limit.
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LIMIT_POS)
    else $error("byte position beyond message limit");

  // While skipping an option body the remaining count is never zero.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (option_phase == dhcp_pkg::PH_SKIP) |-> (skip_remaining != 9'd0))
    else $error("skip phase with zero bytes left");

  // A finished walk holds until the message ends.
  a_walk_hold: assert property (@(posedge clk) disable iff (rst)
    (walk_done && !(step.valid && step.last)) |=> walk_done)
    else $error("option walk restarted inside a message");

endmodule

// ===== rtl/dhcp_out_reg.sv =====
// Result register that holds a classification until the sink takes it.
`timescale 1ns / 1ps

module dhcp_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  dhcp_pkg::dhcp_result_t load_data,
  input  logic                   ready,
  output logic                   valid,
  output dhcp_pkg::dhcp_result_t data
);

  logic valid_next;

  // A load replaces the held item; the sink clears it otherwise.
  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

  // A load never overwrites an item that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!valid || ready))
    else $error("result overwritten before it was taken");

  // A loaded item is shown in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> valid)
    else $error("loaded result not valid");

  // A held item changes only through a new load.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready && !load) |=> (valid && $stable(data)))
    else $error("held result changed");

endmodule

// ===== rtl/dhcp_request_classifier.sv =====
// Top level of the DHCP request classifier: input register, parser and result register.
// Path: each byte is held in the input register; a consumed last byte loads its result
// into the result register, and a last byte waits while an earlier result is untaken.
// Throughput: one byte per cycle; the input stalls only when a last byte meets
// a result register whose item the sink has not yet taken.
// Reset: synchronous rst clears both valid flags and all parser state.
`timescale 1ns / 1ps

module dhcp_request_classifier #(
  parameter int OPTION_AREA_BYTES = dhcp_pkg::OPTION_AREA_BYTES_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  dhcp_in_if.sink    msg,
  dhcp_out_if.source res
);

  logic                   in_valid, in_valid_next;
  logic [7:0]             in_data;
  logic                   in_last;
  logic                   consume;
  logic                   take;
  dhcp_pkg::dhcp_step_t   step;
  dhcp_pkg::dhcp_result_t result;
  dhcp_pkg::dhcp_result_t held;

  // The held byte moves on unless it ends a message and the result slot is busy.
  assign consume = in_valid && (!in_last || !res.valid || res.ready);
  assign msg.ready = !in_valid || consume;
  assign take = msg.valid && msg.ready;

  always_comb begin
    in_valid_next = in_valid;
    if (take) begin
      in_valid_next = 1'b1;
    end else if (consume) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_data <= msg.data_byte;
      in_last <= msg.last_byte;
    end
  end

  assign step.valid = consume;
  assign step.data  = in_data;
  assign step.last  = in_last;

  dhcp_parser #(
    .OPTION_AREA_BYTES(OPTION_AREA_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .result (result)
  );

  dhcp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (consume && in_last),
    .load_data (result),
    .ready     (res.ready),
    .valid     (res.valid),
    .data      (held)
  );

  assign res.status           = held.status;
  assign res.transaction_id   = held.xid;
  assign res.client_addr_high = held.chaddr_high;
  assign res.client_addr_low  = held.chaddr_low;

  // A byte inside a message never blocks the input.
  a_mid_flows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_last) |-> msg.ready)
    else $error("input stalled on a byte inside a message");

  // A last byte waits while the sink holds off a pending result.
  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_last && res.valid && !res.ready) |=> in_valid)
    else $error("last byte dropped while result slot busy");

  // A consumed last byte yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (consume && in_last) |=> res.valid)
    else $error("no result after last byte");

  // Only defined status codes are shown.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.status <= 3'(dhcp_pkg::STATUS_UNSUPPORTED)))
    else $error("undefined status code");

endmodule
